>>> design/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types, sizes and codes for the keyed message store.
// ----------------------------------------------------------------------------
package kms_pkg;

  // Store size and derived widths
  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int FW    = 5;

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_TAKE   = 2'd1;
  localparam logic [1:0] OP_FILTER = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_TAKEN    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FILTER   = 3'd4;

  // One stored message
  typedef struct packed {
    logic [15:0] round;
    logic [15:0] instance_id;
    logic [31:0] payload;
  } entry_t;

  // Shared compare unit results
  typedef struct packed {
    logic eq;   // round and instance both match the keys
    logic ge;   // instance at least the threshold
  } cmp_t;

  // One result item
  typedef struct packed {
    logic [2:0]    status;
    logic          valid_entry;
    entry_t        entry;
    logic [FW-1:0] fill;
    logic          last;
  } res_t;

  // Low bits of the fill count as reported on the output
  function automatic logic [FW-1:0] fill_of(input logic [CW-1:0] c);
    logic [CW+FW-1:0] e;
    e = {{FW{1'b0}}, c};
    return e[FW-1:0];
  endfunction

endpackage

>>> design/kms_mem.sv
// ----------------------------------------------------------------------------
// kms_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kms_mem (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [kms_pkg::AW-1:0]  wr_addr,
  input  kms_pkg::entry_t         wr_data,
  input  logic                    rd_en,
  input  logic [kms_pkg::AW-1:0]  rd_addr,
  output kms_pkg::entry_t         rd_data
);
  import kms_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds its value when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/kms_cmp.sv
// ----------------------------------------------------------------------------
// kms_cmp
// Shared key compare unit, used by the take search and the filter scan.
// ----------------------------------------------------------------------------
module kms_cmp (
  input  kms_pkg::entry_t entry,
  input  logic [15:0]     key_round,
  input  logic [15:0]     key_inst,
  output kms_pkg::cmp_t   res
);
  import kms_pkg::*;

  // Key match and threshold compare (unsigned)
  always_comb begin
    res.eq = (entry.round == key_round) && (entry.instance_id == key_inst);
    res.ge = (entry.instance_id >= key_inst);
  end

endmodule

>>> design/keyed_message_store.sv
// ----------------------------------------------------------------------------
// keyed_message_store
// Ordered message buffer with keyed remove and threshold listing.
//
// Input channel (in_valid/in_ready) carries operation, round, instance_req
// and payload; output channel (out_valid/out_ready) carries one result per
// transfer. in_ready is high only while the sequencer is idle, so one item
// is worked on at a time; a result left in the output register does not
// block the next input transfer. in_ready rises at the edge that loads the
// final result of an item. Add: the entry is written as the result loads.
// Take: entries are read and compared oldest first up to the match; then
// each younger entry is read and written back one place down before the
// result. The shared compare unit and the single memory read port keep the
// search and the shift to one entry at a time.
// Filter: each stored entry is read and compared in turn; a match leaves
// when the next match is found, the last one when the scan ends. An empty
// take or filter goes straight to its result. Unknown operation codes are
// taken and ignored. A stalled receiver holds the output register; the
// sequencer waits before any further result. Reset empties the store and
// drops any pending result; entry memory is kept.
// ----------------------------------------------------------------------------
module keyed_message_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] round,
  input  logic [15:0] instance_req,
  input  logic [31:0] payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        valid_entry,
  output logic [15:0] out_round,
  output logic [15:0] out_instance,
  output logic [31:0] out_payload,
  output logic [4:0]  fill,
  output logic        last
);
  import kms_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD    = 4'd1;
  localparam logic [3:0] S_TREAD  = 4'd2;
  localparam logic [3:0] S_TCMP   = 4'd3;
  localparam logic [3:0] S_SREAD  = 4'd4;
  localparam logic [3:0] S_SWRITE = 4'd5;
  localparam logic [3:0] S_TDONE  = 4'd6;
  localparam logic [3:0] S_FREAD  = 4'd7;
  localparam logic [3:0] S_FCMP   = 4'd8;
  localparam logic [3:0] S_FEND   = 4'd9;

  logic [3:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] idx_inc;
  entry_t        pend, pend_next;
  logic          have_pend, have_pend_next;
  logic          found, found_next;

  logic [1:0]    key_op;
  logic [15:0]   key_round;
  logic [15:0]   key_inst;
  logic [31:0]   key_payload;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;
  cmp_t          cmp;

  logic          emit;
  res_t          emit_res;
  res_t          out_res;
  logic          out_free;
  logic          in_xfer;

  kms_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kms_cmp u_cmp (
    .entry     (rd_data),
    .key_round (key_round),
    .key_inst  (key_inst),
    .res       (cmp)
  );

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign idx_inc  = idx + CW'(1);

  // Sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    pend_next      = pend;
    have_pend_next = have_pend;
    found_next     = found;
    wr_en          = 1'b0;
    wr_addr        = idx[AW-1:0];
    wr_data        = rd_data;
    rd_en          = 1'b0;
    rd_addr        = idx[AW-1:0];
    emit           = 1'b0;
    emit_res       = '0;
    emit_res.fill  = fill_of(count);
    emit_res.last  = 1'b1;

    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          idx_next       = '0;
          found_next     = 1'b0;
          have_pend_next = 1'b0;
          case (operation)
            OP_ADD:    state_next = S_ADD;
            OP_TAKE:   state_next = (count == '0) ? S_TDONE : S_TREAD;
            OP_FILTER: state_next = (count == '0) ? S_FEND : S_FREAD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (count == CW'(DEPTH)) begin
            emit_res.status = ST_FULL;
          end else begin
            wr_en               = 1'b1;
            wr_addr             = count[AW-1:0];
            wr_data.round       = key_round;
            wr_data.instance_id = key_inst;
            wr_data.payload     = key_payload;
            count_next          = count + CW'(1);
            emit_res.status     = ST_ADDED;
            emit_res.fill       = fill_of(count + CW'(1));
          end
        end
      end
      // Take: search oldest first
      S_TREAD: begin
        rd_en      = 1'b1;
        state_next = S_TCMP;
      end
      S_TCMP: begin
        if (cmp.eq) begin
          pend_next  = rd_data;
          found_next = 1'b1;
          state_next = S_SREAD;
        end else if (idx_inc == count) begin
          state_next = S_TDONE;
        end else begin
          idx_next   = idx_inc;
          state_next = S_TREAD;
        end
      end
      // Take: close the gap one entry at a time
      S_SREAD: begin
        if (idx_inc < count) begin
          rd_en      = 1'b1;
          rd_addr    = idx_inc[AW-1:0];
          state_next = S_SWRITE;
        end else begin
          state_next = S_TDONE;
        end
      end
      S_SWRITE: begin
        wr_en      = 1'b1;
        idx_next   = idx_inc;
        state_next = S_SREAD;
      end
      S_TDONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (found) begin
            count_next           = count - CW'(1);
            emit_res.status      = ST_TAKEN;
            emit_res.valid_entry = 1'b1;
            emit_res.entry       = pend;
            emit_res.fill        = fill_of(count - CW'(1));
          end else begin
            emit_res.status = ST_NOTFOUND;
          end
        end
      end
      // Filter: one match held back so the final one can be marked
      S_FREAD: begin
        rd_en      = 1'b1;
        state_next = S_FCMP;
      end
      S_FCMP: begin
        if (!(cmp.ge && have_pend && !out_free)) begin
          if (cmp.ge) begin
            if (have_pend) begin
              emit                 = 1'b1;
              emit_res.status      = ST_FILTER;
              emit_res.valid_entry = 1'b1;
              emit_res.entry       = pend;
              emit_res.last        = 1'b0;
            end
            pend_next      = rd_data;
            have_pend_next = 1'b1;
          end
          if (idx_inc == count) begin
            state_next = S_FEND;
          end else begin
            idx_next   = idx_inc;
            state_next = S_FREAD;
          end
        end
      end
      S_FEND: begin
        if (out_free) begin
          emit                 = 1'b1;
          emit_res.status      = ST_FILTER;
          emit_res.valid_entry = have_pend;
          emit_res.entry       = have_pend ? pend : '0;
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      have_pend <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      have_pend <= have_pend_next;
      found     <= found_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (in_xfer) begin
      key_op      <= operation;
      key_round   <= round;
      key_inst    <= instance_req;
      key_payload <= payload;
    end
    if (emit) begin
      out_res <= emit_res;
    end
  end

  assign status       = out_res.status;
  assign valid_entry  = out_res.valid_entry;
  assign out_round    = out_res.entry.round;
  assign out_instance = out_res.entry.instance_id;
  assign out_payload  = out_res.entry.payload;
  assign fill         = out_res.fill;
  assign last         = out_res.last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_entry_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_entry |-> (status == ST_TAKEN || status == ST_FILTER))
    else $error("entry returned with wrong status");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (count != $past(count)) |->
      out_valid && (status == ST_ADDED || status == ST_TAKEN))
    else $error("fill count changed without add or take result");

  a_take_key: assert property (@(posedge clk) disable iff (rst)
    state == S_TDONE && found |-> key_op == OP_TAKE &&
      pend.round == key_round && pend.instance_id == key_inst)
    else $error("taken entry does not match keys");

endmodule

>>> sim/keyed_message_store_tb.sv
// ----------------------------------------------------------------------------
// keyed_message_store_tb
// Self-checking bench for the keyed message store.
//
// A short table of hand-picked transfers (empty store, field extremes, a full
// store, duplicate keys, the unused opcode) is followed by about 450 random
// transfers. The random part moves through fill-heavy, drain-heavy and mixed
// phases, so the store reaches both empty and full. Most takes use keys that
// are known to be held. A behavioral copy of the store predicts the results
// of the random part and of the table rows without their own expectation.
// Results are checked in order, field by field. Both channels stall
// in random bursts, except in quiet phases and near the end.
module keyed_message_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kms_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         N_DIRECTED   = 27;
  localparam int         N_RANDOM     = 450;
  localparam int         CALM_TAIL    = 60;
  localparam int         PHASE_LEN    = 50;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 100;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] rnd;
    logic [15:0] ins;
    logic [31:0] pay;
    logic        typed;
    logic [2:0]  st;
    logic [4:0]  fl;
  } probe_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  operation    = OP_ADD;
  logic [15:0] round        = '0;
  logic [15:0] instance_req = '0;
  logic [31:0] payload      = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [2:0]  status;
  logic        valid_entry;
  logic [15:0] out_round;
  logic [15:0] out_instance;
  logic [31:0] out_payload;
  logic [4:0]  fill;
  logic        last;

  entry_t held_msgs[$];        // messages held by the store, oldest first
  res_t   step_results[$];     // results of the transfer just made
  res_t   pending_results[$];  // results still to come out of the block
  int     mismatches  = 0;
  int     idle_cycles = 0;
  int     stall_left  = 0;
  bit     quiet       = 1'b0;

  probe_t directed [N_DIRECTED] = '{
    '{OP_TAKE,   16'h1234, 16'h5678, 32'h0000_0000, 1'b1, ST_NOTFOUND, 5'd0},
    '{OP_FILTER, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, ST_FILTER,   5'd0},
    '{OP_ADD,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1, ST_ADDED,    5'd1},
    '{OP_ADD,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_ADDED,    5'd2},
    '{OP_ADD,    16'h0005, 16'h0007, 32'hA5A5_A5A5, 1'b1, ST_ADDED,    5'd3},
    '{OP_ADD,    16'h0001, 16'h8000, 32'h0000_0001, 1'b1, ST_ADDED,    5'd4},
    '{OP_ADD,    16'h0002, 16'h4000, 32'h0000_0002, 1'b1, ST_ADDED,    5'd5},
    '{OP_ADD,    16'h0004, 16'h2000, 32'h0000_0004, 1'b1, ST_ADDED,    5'd6},
    '{OP_ADD,    16'h0008, 16'h1000, 32'h0000_0008, 1'b1, ST_ADDED,    5'd7},
    '{OP_ADD,    16'h0010, 16'h0800, 32'h0000_0010, 1'b1, ST_ADDED,    5'd8},
    '{OP_ADD,    16'h0020, 16'h0400, 32'h0000_0020, 1'b1, ST_ADDED,    5'd9},
    '{OP_ADD,    16'h0040, 16'h0200, 32'h0000_0040, 1'b1, ST_ADDED,    5'd10},
    '{OP_ADD,    16'h0080, 16'h0100, 32'h0000_0080, 1'b1, ST_ADDED,    5'd11},
    '{OP_ADD,    16'h0005, 16'h0007, 32'h5A5A_5A5A, 1'b1, ST_ADDED,    5'd12},
    '{OP_ADD,    16'h0100, 16'h0080, 32'h0000_0100, 1'b1, ST_ADDED,    5'd13},
    '{OP_ADD,    16'h0200, 16'h0040, 32'h0000_0200, 1'b1, ST_ADDED,    5'd14},
    '{OP_ADD,    16'h0400, 16'h0020, 32'h0000_0400, 1'b1, ST_ADDED,    5'd15},
    '{OP_ADD,    16'h0800, 16'h0010, 32'h0000_0800, 1'b1, ST_ADDED,    5'd16},
    '{OP_ADD,    16'h1000, 16'h0008, 32'h0000_1000, 1'b1, ST_FULL,     5'd16},
    '{OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, ST_ADDED,    5'd0},
    '{OP_FILTER, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_ADDED,    5'd0},
    '{OP_FILTER, 16'h0000, 16'hFFFF, 32'h0000_0000, 1'b0, ST_ADDED,    5'd0},
    '{OP_TAKE,   16'h0005, 16'h0007, 32'h0000_0000, 1'b0, ST_ADDED,    5'd0},
    '{OP_TAKE,   16'hFFFF, 16'hFFFF, 32'h0000_0000, 1'b0, ST_ADDED,    5'd0},
    '{OP_TAKE,   16'h0001, 16'h0001, 32'h0000_0000, 1'b1, ST_NOTFOUND, 5'd14},
    '{OP_FILTER, 16'h0000, 16'h8000, 32'h0000_0000, 1'b0, ST_ADDED,    5'd0},
    '{OP_TAKE,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0, ST_ADDED,    5'd0}
  };

  keyed_message_store i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .round        (round),
    .instance_req (instance_req),
    .payload      (payload),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .valid_entry  (valid_entry),
    .out_round    (out_round),
    .out_instance (out_instance),
    .out_payload  (out_payload),
    .fill         (fill),
    .last         (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result with the fill count as it stands after the store update
  function automatic res_t make_result(logic [2:0] st, logic v, entry_t e, logic lst);
    res_t r;
    r             = '0;
    r.status      = st;
    r.valid_entry = v;
    r.entry       = v ? e : '0;
    r.fill        = 5'(held_msgs.size());
    r.last        = lst;
    return r;
  endfunction

  // Apply one transfer to the store copy and collect the results it causes
  task automatic store_apply(input logic [1:0] op, input logic [15:0] r,
                             input logic [15:0] i, input logic [31:0] p);
    entry_t e;
    int     hit;
    int     last_hit;
    step_results.delete();
    case (op)
      OP_ADD: begin
        if (held_msgs.size() >= DEPTH) begin
          step_results.push_back(make_result(ST_FULL, 1'b0, '0, 1'b1));
        end else begin
          e.round       = r;
          e.instance_id = i;
          e.payload     = p;
          held_msgs.push_back(e);
          step_results.push_back(make_result(ST_ADDED, 1'b0, '0, 1'b1));
        end
      end
      OP_TAKE: begin
        hit = -1;
        foreach (held_msgs[k]) begin
          if (hit < 0 && held_msgs[k].round == r && held_msgs[k].instance_id == i) hit = k;
        end
        if (hit >= 0) begin
          e = held_msgs[hit];
          held_msgs.delete(hit);
          step_results.push_back(make_result(ST_TAKEN, 1'b1, e, 1'b1));
        end else begin
          step_results.push_back(make_result(ST_NOTFOUND, 1'b0, '0, 1'b1));
        end
      end
      OP_FILTER: begin
        last_hit = -1;
        foreach (held_msgs[k]) begin
          if (held_msgs[k].instance_id >= i) last_hit = k;
        end
        foreach (held_msgs[k]) begin
          if (held_msgs[k].instance_id >= i)
            step_results.push_back(make_result(ST_FILTER, 1'b1, held_msgs[k], k == last_hit));
        end
        if (last_hit < 0) step_results.push_back(make_result(ST_FILTER, 1'b0, '0, 1'b1));
      end
      default: ;  // unused opcode: no effect, no result
    endcase
  endtask

  // Present one item and wait for its transfer
  task automatic send_item(input logic [1:0] op, input logic [15:0] r,
                           input logic [15:0] i, input logic [31:0] p);
    in_valid     <= 1'b1;
    operation    <= op;
    round        <= r;
    instance_req <= i;
    payload      <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    store_apply(op, r, i, p);
  endtask

  // Occasional sender gap
  task automatic maybe_pause();
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Key drawn from a tiny pool half the time so duplicates and near misses occur
  function automatic logic [15:0] draw_key();
    if ($urandom_range(0, 1) == 1) return 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  task automatic note_mismatch(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp st=%0d v=%0d r=%h i=%h p=%h f=%0d l=%0d | got st=%0d v=%0d r=%h i=%h p=%h f=%0d l=%0d",
               $realtime, what,
               want.status, want.valid_entry, want.entry.round, want.entry.instance_id,
               want.entry.payload, want.fill, want.last,
               got.status, got.valid_entry, got.entry.round, got.entry.instance_id,
               got.entry.payload, got.fill, got.last);
  endtask

  // Receiver stalls in bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && out_ready) begin
      got.status            = status;
      got.valid_entry       = valid_entry;
      got.entry.round       = out_round;
      got.entry.instance_id = out_instance;
      got.entry.payload     = out_payload;
      got.fill              = fill;
      got.last              = last;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.valid_entry !== want.valid_entry ||
            got.entry.round !== want.entry.round ||
            got.entry.instance_id !== want.entry.instance_id ||
            got.entry.payload !== want.entry.payload ||
            got.fill !== want.fill || got.last !== want.last)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    res_t        typed_res;
    entry_t      e;
    logic [1:0]  op;
    logic [15:0] r;
    logic [15:0] i;
    int          counted;
    int          phase;
    int          cur_phase;
    int          pick;
    int          add_max;
    int          take_max;

    repeat (6) @(posedge clk);
    rst   <= 1'b0;
    quiet <= ($urandom_range(0, 3) == 0);

    // Directed table
    foreach (directed[k]) begin
      send_item(directed[k].op, directed[k].rnd, directed[k].ins, directed[k].pay);
      if (directed[k].typed) begin
        typed_res        = '0;
        typed_res.status = directed[k].st;
        typed_res.fill   = directed[k].fl;
        typed_res.last   = 1'b1;
        pending_results.push_back(typed_res);
      end else begin
        foreach (step_results[j]) pending_results.push_back(step_results[j]);
      end
      maybe_pause();
    end

    // Random part, in phases that push the store toward full or toward empty
    counted   = 0;
    cur_phase = -1;
    add_max   = 40;
    take_max  = 75;
    while (counted < N_RANDOM) begin
      phase = counted / PHASE_LEN;
      if (phase != cur_phase) begin
        cur_phase = phase;
        case (phase % 3)
          0:       begin add_max = 60; take_max = 85; end
          1:       begin add_max = 25; take_max = 75; end
          default: begin add_max = 40; take_max = 75; end
        endcase
        quiet <= (counted >= N_RANDOM - CALM_TAIL) || ($urandom_range(0, 3) == 0);
      end
      if (counted == N_RANDOM - CALM_TAIL) quiet <= 1'b1;

      pick = $urandom_range(0, 99);
      r    = draw_key();
      i    = draw_key();
      if (pick < add_max) begin
        op = OP_ADD;
      end else if (pick < take_max) begin
        op = OP_TAKE;
        if (held_msgs.size() > 0 && $urandom_range(0, 4) != 0) begin
          e = held_msgs[$urandom_range(0, held_msgs.size() - 1)];
          r = e.round;
          i = e.instance_id;
        end
      end else if (pick < 96) begin
        op = OP_FILTER;
        case ($urandom_range(0, 3))
          0: i = '0;
          1: if (held_msgs.size() > 0)
               i = held_msgs[$urandom_range(0, held_msgs.size() - 1)].instance_id;
          default: ;
        endcase
      end else begin
        op = OP_UNUSED;
      end

      send_item(op, r, i, $urandom);
      foreach (step_results[j]) pending_results.push_back(step_results[j]);
      if (op != OP_UNUSED) counted++;
      maybe_pause();
    end
    in_valid <= 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
